@@ hw/rtl/latp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// latp_pkg
// Types and constants shared by the LED animation text parser.
// ----------------------------------------------------------------------------
package latp_pkg;

  typedef enum logic [4:0] {
    PH_SEEK_OPEN     = 5'd0,
    PH_FIND_BOARD    = 5'd1,
    PH_FIND_LBRACKET = 5'd2,
    PH_BOARD_SCAN    = 5'd3,
    PH_R_PRE         = 5'd4,
    PH_R_NUM         = 5'd5,
    PH_R_POST        = 5'd6,
    PH_G_PRE         = 5'd7,
    PH_G_NUM         = 5'd8,
    PH_G_POST        = 5'd9,
    PH_B_PRE         = 5'd10,
    PH_B_NUM         = 5'd11,
    PH_AFTER_TRIPLET = 5'd12,
    PH_FIND_TIME     = 5'd13,
    PH_FIND_COLON    = 5'd14,
    PH_T_PRE         = 5'd15,
    PH_T_NUM         = 5'd16,
    PH_FIND_CLOSE    = 5'd17
  } phase_t;

  localparam logic [1:0] KIND_SQUARE = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [3:0] ERR_NEGATIVE   = 4'd0;
  localparam logic [3:0] ERR_NOT_NUMBER = 4'd1;
  localparam logic [3:0] ERR_COLOUR     = 4'd2;
  localparam logic [3:0] ERR_NO_BOARD   = 4'd3;
  localparam logic [3:0] ERR_NO_BRACKET = 4'd4;
  localparam logic [3:0] ERR_COUNT      = 4'd5;
  localparam logic [3:0] ERR_NO_TIME    = 4'd6;
  localparam logic [3:0] ERR_NO_COLON   = 4'd7;
  localparam logic [3:0] ERR_TIME_OVF   = 4'd8;

  localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  square_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [30:0] display_time;
    logic [3:0]  error_code;
  } result_t;

  // class of a text byte, decided in the front part
  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
    logic       space;
    logic       digit;
    logic       term;
    logic [3:0] dval;
  } cls_t;

endpackage
`default_nettype wire

@@ hw/rtl/latp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// latp_front
// Accepts text bytes, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module latp_front
  import latp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            q_valid,
  output cls_t            q_data,
  input  wire logic       q_pop
);

  cls_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cls_t       c;
  logic       push;

  always_comb begin
    c.eot   = in_end_of_text;
    c.ch    = in_text_byte;
    c.space = (in_text_byte == 8'd32) || (in_text_byte >= 8'd9 && in_text_byte <= 8'd13);
    c.digit = (in_text_byte >= 8'd48) && (in_text_byte <= 8'd57);
    c.term  = c.space || (in_text_byte == 8'd44) || (in_text_byte == 8'd93);
    c.dval  = 4'(in_text_byte - 8'd48);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/latp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// latp_back
// Runs the parse state machine on classified bytes and holds one result.
// ----------------------------------------------------------------------------
module latp_back
  import latp_pkg::*;
#(
  parameter int SQUARE_COUNT = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire cls_t  q_data,
  output logic       q_pop,
  output logic       res_valid,
  output result_t    res,
  input  wire logic  res_ready
);

  localparam logic [6:0] SQ_N = 7'(SQUARE_COUNT);

  phase_t      ph_r, ph_nxt;
  logic [3:0]  kp_r, kp_nxt;
  logic [6:0]  sq_r, sq_nxt;
  logic [8:0]  ra_r, ga_r, ba_r, ra_nxt, ga_nxt, ba_nxt;
  logic [30:0] ta_r, ta_nxt;
  logic        halt_r, halt_nxt;
  logic        ov_r, ov_nxt;
  result_t     res_r, res_nxt;
  logic        emit;

  logic [8:0]  acc_sel, acc_new;
  logic [12:0] acc_mul;
  logic [34:0] t_mul;
  logic [7:0]  kch;

  function automatic logic [7:0] board_ch(input logic [3:0] p);
    unique case (p)
      4'd0: board_ch = 8'h22;
      4'd1: board_ch = 8'h62;
      4'd2: board_ch = 8'h6f;
      4'd3: board_ch = 8'h61;
      4'd4: board_ch = 8'h72;
      4'd5: board_ch = 8'h64;
      default: board_ch = 8'h22;
    endcase
  endfunction

  function automatic logic [7:0] time_ch(input logic [3:0] p);
    unique case (p)
      4'd0: time_ch = 8'h22;
      4'd1: time_ch = 8'h74;
      4'd2: time_ch = 8'h69;
      4'd3: time_ch = 8'h6d;
      4'd4: time_ch = 8'h65;
      4'd5: time_ch = 8'h5f;
      4'd6: time_ch = 8'h6d;
      4'd7: time_ch = 8'h73;
      default: time_ch = 8'h22;
    endcase
  endfunction

  // digit arriving in a post state starts the next colour from zero-stripped acc
  function automatic logic [8:0] acc_new_g(input logic [8:0] a);
    logic [12:0] m;
    m = 13'(a) * 13'd10 + 13'(q_data.dval);
    acc_new_g = (m > 13'd256) ? 9'd256 : m[8:0];
  endfunction

  assign q_pop     = q_valid && (!ov_r || res_ready);
  assign res_valid = ov_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_SEEK_OPEN;
      kp_r   <= 4'd0;
      sq_r   <= 7'd0;
      ra_r   <= 9'd0;
      ga_r   <= 9'd0;
      ba_r   <= 9'd0;
      ta_r   <= 31'd0;
      halt_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      kp_r   <= kp_nxt;
      sq_r   <= sq_nxt;
      ra_r   <= ra_nxt;
      ga_r   <= ga_nxt;
      ba_r   <= ba_nxt;
      ta_r   <= ta_nxt;
      halt_r <= halt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_comb begin
    logic [8:0] acc_in;
    logic       over;
    logic       blue_done;
    logic [3:0] p;
    logic [3:0] len;
    ph_nxt   = ph_r;
    kp_nxt   = kp_r;
    sq_nxt   = sq_r;
    ra_nxt   = ra_r;
    ga_nxt   = ga_r;
    ba_nxt   = ba_r;
    ta_nxt   = ta_r;
    halt_nxt = halt_r;
    emit     = 1'b0;
    res_nxt  = res_r;
    blue_done = 1'b0;
    acc_in   = 9'd0;
    p        = 4'd0;
    len      = 4'd0;
    kch      = 8'd0;
    over     = (ra_r > 9'd255) || (ga_r > 9'd255) || (ba_r > 9'd255);

    // multiply-by-ten with saturation at 256, shared by the three colours in the pre and number states
    unique case (ph_r)
      PH_R_PRE, PH_R_NUM: acc_sel = ra_r;
      PH_G_PRE, PH_G_NUM: acc_sel = ga_r;
      default:            acc_sel = ba_r;
    endcase
    acc_mul = 13'(acc_sel) * 13'd10 + 13'(q_data.dval);
    acc_new = (acc_mul > 13'd256) ? 9'd256 : acc_mul[8:0];
    t_mul   = 35'(ta_r) * 35'd10 + 35'(q_data.dval);
    acc_in  = acc_new;

    if (ph_r == PH_FIND_BOARD) begin
      len = 4'd7;
    end else begin
      len = 4'd9;
    end
    p = (kp_r >= len) ? 4'd0 : kp_r;
    kch = (ph_r == PH_FIND_BOARD) ? board_ch(p) : time_ch(p);

    res_nxt.kind         = KIND_ERROR;
    res_nxt.square_index = 6'd0;
    res_nxt.red          = 8'd0;
    res_nxt.green        = 8'd0;
    res_nxt.blue         = 8'd0;
    res_nxt.display_time = 31'd0;
    res_nxt.error_code   = 4'd0;

    if (q_pop) begin
      if (q_data.eot) begin
        if (!halt_r) begin
          emit = 1'b1;
          unique case (ph_r)
            PH_FIND_BOARD:    res_nxt.error_code = ERR_NO_BOARD;
            PH_FIND_LBRACKET: res_nxt.error_code = ERR_NO_BRACKET;
            PH_BOARD_SCAN, PH_AFTER_TRIPLET:
              res_nxt.error_code = (sq_r != SQ_N) ? ERR_COUNT : ERR_NO_TIME;
            PH_R_PRE, PH_R_NUM, PH_R_POST, PH_G_PRE, PH_G_NUM, PH_G_POST,
            PH_B_PRE, PH_B_NUM: begin
              if (over) res_nxt.error_code = ERR_COLOUR;
              else res_nxt.error_code = (sq_r + 7'd1 != SQ_N) ? ERR_COUNT : ERR_NO_TIME;
            end
            PH_FIND_TIME:  res_nxt.error_code = ERR_NO_TIME;
            PH_FIND_COLON: res_nxt.error_code = ERR_NO_COLON;
            PH_T_PRE, PH_T_NUM: begin
              res_nxt.kind = KIND_FRAME;
              res_nxt.display_time = ta_r;
            end
            default: emit = 1'b0;
          endcase
        end
        ph_nxt = PH_SEEK_OPEN; kp_nxt = 4'd0; sq_nxt = 7'd0;
        ra_nxt = 9'd0; ga_nxt = 9'd0; ba_nxt = 9'd0; ta_nxt = 31'd0;
        halt_nxt = 1'b0;
      end else if (!halt_r) begin
        unique case (ph_r)
          PH_FIND_BOARD, PH_FIND_TIME: begin
            if (q_data.ch == kch) p = p + 4'd1;
            else p = (q_data.ch == 8'h22) ? 4'd1 : 4'd0;
            if (p >= len) begin
              kp_nxt = 4'd0;
              ph_nxt = (ph_r == PH_FIND_BOARD) ? PH_FIND_LBRACKET : PH_FIND_COLON;
            end else begin
              kp_nxt = p;
            end
          end
          PH_FIND_LBRACKET: begin
            if (q_data.ch == 8'h5b) begin
              ph_nxt = PH_BOARD_SCAN; sq_nxt = 7'd0;
            end
          end
          PH_BOARD_SCAN, PH_AFTER_TRIPLET, PH_R_POST, PH_G_POST: begin
            // post states fall through into the next pre state on a non-comma
            if (ph_r == PH_AFTER_TRIPLET && q_data.space) begin
            end else if (ph_r == PH_AFTER_TRIPLET && q_data.ch == 8'h5d) begin
              ph_nxt = PH_BOARD_SCAN;
            end else if ((ph_r == PH_R_POST || ph_r == PH_G_POST)) begin
              if (q_data.space) begin
              end else if (q_data.ch == 8'h2c) begin
                ph_nxt = phase_t'(ph_r + 5'd1);
              end else if (q_data.ch == 8'h2d) begin
                emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_NEGATIVE;
              end else if (q_data.digit) begin
                if (ph_r == PH_R_POST) ga_nxt = acc_new_g(ga_r);
                else ba_nxt = acc_new_g(ba_r);
                ph_nxt = phase_t'(ph_r + 5'd2);
              end else if (!q_data.term) begin
                emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_NOT_NUMBER;
              end else begin
                // ']' runs through the remaining colours and closes the triplet
                blue_done = 1'b1;
              end
            end else if (q_data.ch == 8'h5b) begin
              if (sq_r >= SQ_N) begin
                emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_COUNT;
              end else begin
                ra_nxt = 9'd0; ga_nxt = 9'd0; ba_nxt = 9'd0; ph_nxt = PH_R_PRE;
              end
            end else if (q_data.ch == 8'h5d) begin
              if (sq_r != SQ_N) begin
                emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_COUNT;
              end else begin
                ph_nxt = PH_FIND_TIME; kp_nxt = 4'd0;
              end
            end else begin
              ph_nxt = PH_BOARD_SCAN;
            end
          end
          PH_R_PRE, PH_R_NUM, PH_G_PRE, PH_G_NUM, PH_B_PRE, PH_B_NUM: begin
            if ((ph_r == PH_R_PRE || ph_r == PH_G_PRE || ph_r == PH_B_PRE)
                && q_data.space) begin
            end else if ((ph_r == PH_R_PRE || ph_r == PH_G_PRE || ph_r == PH_B_PRE)
                && q_data.ch == 8'h2d) begin
              emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_NEGATIVE;
            end else if (q_data.digit) begin
              if (ph_r == PH_R_PRE || ph_r == PH_R_NUM) begin
                ra_nxt = acc_in; ph_nxt = PH_R_NUM;
              end else if (ph_r == PH_G_PRE || ph_r == PH_G_NUM) begin
                ga_nxt = acc_in; ph_nxt = PH_G_NUM;
              end else begin
                ba_nxt = acc_in; ph_nxt = PH_B_NUM;
              end
            end else if (!q_data.term) begin
              emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_NOT_NUMBER;
            end else if (ph_r == PH_B_PRE || ph_r == PH_B_NUM) begin
              blue_done = 1'b1;
            end else begin
              // terminator is handled as the post state would: a space enters it, a comma or ']' passes on
              if (q_data.space) begin
                ph_nxt = (ph_r == PH_R_PRE || ph_r == PH_R_NUM) ? PH_R_POST : PH_G_POST;
              end else if (q_data.ch == 8'h2c) begin
                ph_nxt = (ph_r == PH_R_PRE || ph_r == PH_R_NUM) ? PH_G_PRE : PH_B_PRE;
              end else begin
                blue_done = 1'b1; // ']' runs through the post and pre states
              end
            end
          end
          PH_FIND_COLON: begin
            if (q_data.ch == 8'h3a) begin
              ph_nxt = PH_T_PRE; ta_nxt = 31'd0;
            end
          end
          PH_T_PRE, PH_T_NUM: begin
            if (ph_r == PH_T_PRE && q_data.space) begin
            end else if (ph_r == PH_T_PRE && q_data.ch == 8'h2d) begin
              emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_NEGATIVE;
            end else if (q_data.digit) begin
              if (t_mul > 35'(TIME_MAX)) begin
                emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_TIME_OVF;
              end else begin
                ta_nxt = t_mul[30:0]; ph_nxt = PH_T_NUM;
              end
            end else if (q_data.term) begin
              emit = 1'b1; res_nxt.kind = KIND_FRAME;
              res_nxt.display_time = ta_r; ph_nxt = PH_FIND_CLOSE;
            end else begin
              emit = 1'b1; halt_nxt = 1'b1; res_nxt.error_code = ERR_NOT_NUMBER;
            end
          end
          PH_FIND_CLOSE: begin
            if (q_data.ch == 8'h7d) ph_nxt = PH_SEEK_OPEN;
          end
          default: begin
            ph_nxt = PH_SEEK_OPEN;
            if (q_data.ch == 8'h7b) begin
              ph_nxt = PH_FIND_BOARD; kp_nxt = 4'd0;
            end
          end
        endcase
        if (blue_done) begin
          emit = 1'b1;
          if (over) begin
            halt_nxt = 1'b1; res_nxt.error_code = ERR_COLOUR;
          end else begin
            res_nxt.kind = KIND_SQUARE;
            res_nxt.square_index = sq_r[5:0];
            res_nxt.red   = ra_r[7:0];
            res_nxt.green = ga_r[7:0];
            res_nxt.blue  = ba_r[7:0];
            sq_nxt = sq_r + 7'd1;
            ph_nxt = q_data.space ? PH_AFTER_TRIPLET : PH_BOARD_SCAN;
          end
        end
      end
    end
    if (!emit) res_nxt = res_r;
    ov_nxt = emit ? 1'b1 : (res_ready ? 1'b0 : ov_r);
  end

endmodule
`default_nettype wire

@@ hw/rtl/led_animation_text_parser_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// led_animation_text_parser_core
// Streaming parser of LED animation text into square, frame and error results.
// ----------------------------------------------------------------------------
// usage:
//   in_ channel carries one text byte per transaction, or an end-of-text mark
//   with in_end_of_text high. out_ channel carries at most one result per
//   input transaction: a square colour, a frame time or an error.
//   order: a byte sits in the input queue, then the state machine pops it
//   and registers its result, which stays on out_ until out_ready takes it.
//   throughput: one byte per cycle while no result waits on out_ready, set
//   by the state update with its multiply-by-ten accumulate.
//   a two-entry queue parts the front from the state machine; while a result
//   waits on out_ready no byte leaves the queue, and in_ready drops once two
//   bytes are held there.
//   reset (rst_n low, synchronous) empties the queue and returns the parser
//   to seeking an opening brace, with no result pending.
// ----------------------------------------------------------------------------
module led_animation_text_parser_core
  import latp_pkg::*;
#(
  parameter int SQUARE_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [5:0]       out_square_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [30:0]      out_display_time,
  output logic [3:0]       out_error_code
);

  logic    q_valid, q_pop;
  cls_t    q_data;
  result_t res;

  latp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_text_byte, .in_end_of_text,
    .q_valid, .q_data, .q_pop
  );

  latp_back #(.SQUARE_COUNT(SQUARE_COUNT)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .res_valid(out_valid), .res, .res_ready(out_ready)
  );

  assign out_result_kind  = res.kind;
  assign out_square_index = res.square_index;
  assign out_red          = res.red;
  assign out_green        = res.green;
  assign out_blue         = res.blue;
  assign out_display_time = res.display_time;
  assign out_error_code   = res.error_code;

endmodule
`default_nettype wire

@@ hw/rtl/latp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// latp_checker
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
module latp_checker
  import latp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_result_kind,
  input wire logic [5:0]  out_square_index,
  input wire logic [7:0]  out_red,
  input wire logic [30:0] out_display_time,
  input wire logic [3:0]  out_error_code
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind))
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind != 2'd3)
    else $error("bad result kind");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_ERROR |-> out_error_code <= ERR_TIME_OVF)
    else $error("bad error code");

  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_FRAME |-> out_square_index == 6'd0
      && out_red == 8'd0)
    else $error("frame carries square fields");

endmodule

bind led_animation_text_parser_core latp_checker u_latp_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_result_kind, .out_square_index,
  .out_red, .out_display_time, .out_error_code
);
`default_nettype wire

@@ bench/led_animation_text_parser_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_animation_text_parser_core_tb
// Checks the text parser against a behavioral model of its state machine.
// Animation objects with random colours, spacing and times, broken objects
// and noise make up the stream and drive the error paths.
// Both channels stall at random and results are compared in order.
// ----------------------------------------------------------------------------
module led_animation_text_parser_core_tb
  import latp_pkg::*;
();

  localparam int SQUARES = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_text_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_result_kind;
  logic [5:0]  out_square_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [30:0] out_display_time;
  logic [3:0]  out_error_code;

  led_animation_text_parser_core dut (.*);

  text_item_t pending_text[$];
  result_t    expected_results[$];
  int         mismatch_count;
  int         result_count;
  int         item_count;

  // parser state mirror
  phase_t      ph;
  int unsigned key_pos;
  int unsigned squares;
  int unsigned acc_r, acc_g, acc_b;
  logic [30:0] time_acc;
  bit          halted;

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_end_char(logic [7:0] c);
    return c == "," || c == "]" || is_ws(c);
  endfunction

  task automatic clear_parser();
    ph = PH_SEEK_OPEN; key_pos = 0; squares = 0;
    acc_r = 0; acc_g = 0; acc_b = 0; time_acc = '0; halted = 0;
  endtask

  function automatic bit match_key(string word, logic [7:0] c);
    int unsigned p;
    p = key_pos & 15;
    if (p >= word.len()) p = 0;
    if (c == word[p]) p++;
    else p = (c == "\"") ? 1 : 0;
    if (p >= word.len()) begin
      key_pos = 0;
      return 1;
    end
    key_pos = p;
    return 0;
  endfunction

  task automatic expect_result(result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic push_error(logic [3:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    halted = 1;
    expect_result(r);
  endtask

  task automatic push_frame();
    result_t r;
    r = '0;
    r.kind = KIND_FRAME;
    r.display_time = time_acc;
    ph = PH_FIND_CLOSE;
    expect_result(r);
  endtask

  task automatic parse_byte(logic [7:0] c);
    result_t     r;
    int unsigned comp, v;
    bit          pre;
    longint unsigned tv;
    forever begin
      case (ph)
        PH_FIND_BOARD: begin
          if (match_key("\"board\"", c)) ph = PH_FIND_LBRACKET;
          return;
        end
        PH_FIND_LBRACKET: begin
          if (c == "[") begin
            ph = PH_BOARD_SCAN; squares = 0;
          end
          return;
        end
        PH_BOARD_SCAN: begin
          if (c == "[") begin
            if (squares >= SQUARES) begin
              push_error(ERR_COUNT);
              return;
            end
            acc_r = 0; acc_g = 0; acc_b = 0;
            ph = PH_R_PRE;
          end else if (c == "]") begin
            if (squares != SQUARES) begin
              push_error(ERR_COUNT);
              return;
            end
            ph = PH_FIND_TIME; key_pos = 0;
          end
          return;
        end
        PH_R_PRE, PH_R_NUM, PH_G_PRE, PH_G_NUM, PH_B_PRE, PH_B_NUM: begin
          comp = (ph - PH_R_PRE) / 3;
          pre = ((ph - PH_R_PRE) % 3) == 0;
          if (pre && is_ws(c)) return;
          if (pre && c == "-") begin
            push_error(ERR_NEGATIVE);
            return;
          end
          if (is_dig(c)) begin
            case (comp)
              0: begin
                v = (acc_r > 256 ? 256 : acc_r) * 10 + (c - "0");
                acc_r = v > 256 ? 256 : v;
              end
              1: begin
                v = (acc_g > 256 ? 256 : acc_g) * 10 + (c - "0");
                acc_g = v > 256 ? 256 : v;
              end
              default: begin
                v = (acc_b > 256 ? 256 : acc_b) * 10 + (c - "0");
                acc_b = v > 256 ? 256 : v;
              end
            endcase
            ph = phase_t'(PH_R_PRE + comp * 3 + 1);
            return;
          end
          if (!is_end_char(c)) begin
            push_error(ERR_NOT_NUMBER);
            return;
          end
          if (comp >= 2) begin
            if (acc_r > 255 || acc_g > 255 || acc_b > 255) begin
              push_error(ERR_COLOUR);
              return;
            end
            r = '0;
            r.kind = KIND_SQUARE;
            r.square_index = squares[5:0];
            r.red = acc_r[7:0];
            r.green = acc_g[7:0];
            r.blue = acc_b[7:0];
            expect_result(r);
            squares = (squares + 1) & 127;
            ph = is_ws(c) ? PH_AFTER_TRIPLET : PH_BOARD_SCAN;
            return;
          end
          ph = phase_t'(PH_R_PRE + comp * 3 + 2);
        end
        PH_R_POST, PH_G_POST: begin
          if (is_ws(c)) return;
          ph = phase_t'(ph + 1);
          if (c == ",") return;
        end
        PH_AFTER_TRIPLET: begin
          if (is_ws(c)) return;
          ph = PH_BOARD_SCAN;
          if (c == "]") return;
        end
        PH_FIND_TIME: begin
          if (match_key("\"time_ms\"", c)) ph = PH_FIND_COLON;
          return;
        end
        PH_FIND_COLON: begin
          if (c == ":") begin
            ph = PH_T_PRE; time_acc = '0;
          end
          return;
        end
        PH_T_PRE, PH_T_NUM: begin
          if (ph == PH_T_PRE && is_ws(c)) return;
          if (ph == PH_T_PRE && c == "-") begin
            push_error(ERR_NEGATIVE);
            return;
          end
          if (is_dig(c)) begin
            tv = longint'(time_acc) * 10 + (c - "0");
            if (tv > TIME_MAX) begin
              push_error(ERR_TIME_OVF);
              return;
            end
            time_acc = tv[30:0];
            ph = PH_T_NUM;
            return;
          end
          if (is_end_char(c)) push_frame();
          else push_error(ERR_NOT_NUMBER);
          return;
        end
        PH_FIND_CLOSE: begin
          if (c == "}") ph = PH_SEEK_OPEN;
          return;
        end
        default: begin
          ph = PH_SEEK_OPEN;
          if (c == "{") begin
            ph = PH_FIND_BOARD; key_pos = 0;
          end
          return;
        end
      endcase
    end
  endtask

  task automatic close_text();
    if (!halted) begin
      case (ph)
        PH_FIND_BOARD:    push_error(ERR_NO_BOARD);
        PH_FIND_LBRACKET: push_error(ERR_NO_BRACKET);
        PH_BOARD_SCAN, PH_AFTER_TRIPLET:
          push_error(squares != SQUARES ? ERR_COUNT : ERR_NO_TIME);
        PH_R_PRE, PH_R_NUM, PH_R_POST, PH_G_PRE, PH_G_NUM, PH_G_POST,
        PH_B_PRE, PH_B_NUM: begin
          if (acc_r > 255 || acc_g > 255 || acc_b > 255) push_error(ERR_COLOUR);
          else push_error(squares + 1 != SQUARES ? ERR_COUNT : ERR_NO_TIME);
        end
        PH_FIND_TIME:       push_error(ERR_NO_TIME);
        PH_FIND_COLON:      push_error(ERR_NO_COLON);
        PH_T_PRE, PH_T_NUM: push_frame();
        default: ;
      endcase
    end
    clear_parser();
  endtask

  task automatic predict_item(text_item_t it);
    item_count++;
    if (it.eot) close_text();
    else if (!halted) parse_byte(it.ch);
  endtask

  // ---------------- stimulus builders
  task automatic add_item(logic [7:0] c, logic eot);
    text_item_t t;
    t.ch = c;
    t.eot = eot;
    pending_text.insert(pending_text.size(), t);
  endtask

  task automatic add_char(logic [7:0] c);
    add_item(c, 1'b0);
  endtask

  task automatic add_str(string s);
    foreach (s[i]) add_char(s[i]);
  endtask

  task automatic add_eot();
    add_item(8'($urandom), 1'b1);
  endtask

  task automatic add_ws();
    int n;
    logic [7:0] ws[6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) add_char(ws[$urandom_range(0, 5)]);
  endtask

  task automatic add_colour();
    int unsigned v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 255;
      2: v = 0;  // leading zeros below
      default: v = $urandom_range(0, 255);
    endcase
    if ($urandom_range(0, 15) == 0) return;  // missing number reads as 0
    if ($urandom_range(0, 7) == 0) add_str("00");
    add_str($sformatf("%0d", v));
  endtask

  // one board object; count and faults vary the shape, compact boards use
  // mostly empty triplets
  task automatic add_object(int count, int fault, bit compact);
    int k;
    add_ws(); add_char("{"); add_ws();
    if ($urandom_range(0, 3) == 0) add_str("\"bo\"x");
    add_str("\"board\""); add_ws(); add_char(":"); add_ws(); add_char("[");
    for (k = 0; k < count; k++) begin
      if (compact && fault == 0 && $urandom_range(0, 15) != 0) begin
        add_str("[]");
        continue;
      end
      add_ws(); add_char("[");
      add_colour(); add_char(","); add_ws();
      add_colour();
      if ($urandom_range(0, 1)) add_char(","); else add_char(" ");
      add_colour();
      if (fault == 1 && k == count / 2) begin
        add_str("9999]");  // colour over range
        return;
      end
      if (fault == 2 && k == count / 2) begin
        add_char("x");
        return;
      end
      if ($urandom_range(0, 3) == 0) add_ws();
      add_char("]");
      if (k != count - 1) add_char(",");
    end
    add_ws(); add_char("]"); add_char(","); add_ws();
    add_str("\"time_ms\""); add_ws(); add_char(":"); add_ws();
    case ($urandom_range(0, 9))
      0: add_str("2147483647");
      1: add_str("0");
      2: add_str("2147483648");
      default: add_str($sformatf("%0d", $urandom_range(0, 100000)));
    endcase
    add_ws();
    if ($urandom_range(0, 7) == 0) add_char("}");  // time ended by brace
    else begin
      add_char(","); add_ws(); add_char("}");
    end
  endtask

  task automatic add_noise(int n);
    string alpha;
    alpha = "{}[]\":,-0123456789 bx";
    repeat (n) begin
      if ($urandom_range(0, 1)) add_char(8'($urandom));
      else add_char(alpha[$urandom_range(0, 20)]);
    end
  endtask

  // ---------------- clock, reset and limit
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $display("timeout: %0d results checked, %0d still expected",
             result_count, expected_results.size());
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // ---------------- driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_text_byte <= '0;
      in_end_of_text <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_item('{ch: in_text_byte, eot: in_end_of_text});
      if (in_gap > 0 || pending_text.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        text_item_t it;
        it = pending_text.pop_front();
        in_valid <= 1'b1;
        in_text_byte <= it.ch;
        in_end_of_text <= it.eot;
        in_gap <= pick_gap();
      end
    end
  end

  // ---------------- monitor
  int out_gap;
  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("mismatch @%0t result %0d %s: got %0d expected %0d",
             $realtime, result_count, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        result_t e;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected kind", out_result_kind, -1);
        end else begin
          e = expected_results.pop_front();
          if (out_result_kind != e.kind) report_mismatch("kind", out_result_kind, e.kind);
          if (out_square_index != e.square_index)
            report_mismatch("square", out_square_index, e.square_index);
          if (out_red != e.red) report_mismatch("red", out_red, e.red);
          if (out_green != e.green) report_mismatch("green", out_green, e.green);
          if (out_blue != e.blue) report_mismatch("blue", out_blue, e.blue);
          if (out_display_time != e.display_time)
            report_mismatch("time", out_display_time, e.display_time);
          if (out_error_code != e.error_code)
            report_mismatch("error", out_error_code, e.error_code);
        end
        result_count++;
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
    end
  end

  // ---------------- test sequence
  int unsigned k;
  initial begin
    rst_n = 0;
    mismatch_count = 0; result_count = 0; item_count = 0;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: end of text in the early seeking phases, a negative colour and one over range
    add_eot();
    add_str("{x"); add_eot();
    add_str("{\"board\""); add_eot();
    add_str("{\"board\"[[-"); add_eot();
    add_str("{\"board\"[[1,2"); add_eot();
    add_str("{\"board\"[[300 1 1"); add_eot();
    add_str("{\"board\"[]"); add_eot();
    add_char(8'hff); add_char(8'h00); add_eot();

    // short broken objects, then full boards: good, one triplet too many,
    // and one with its last three bytes cut off
    add_object(4, 1, 1'b0); add_eot();
    add_object(4, 2, 1'b0); add_eot();
    add_object(SQUARES, 0, 1'b1); add_eot();
    add_object(SQUARES + 1, 0, 1'b1); add_eot();
    add_object(SQUARES, 0, 1'b1);
    pending_text = pending_text[0:pending_text.size() - 4];
    add_eot();

    while (pending_text.size() < 820) begin
      k = $urandom_range(0, 2);
      if (k == 0) add_object($urandom_range(0, 4), $urandom_range(0, 2), 1'b0);
      else if (k == 1) add_noise($urandom_range(1, 20));
      else begin
        add_str("{\"board\":[[1,2,3]");
        add_noise($urandom_range(0, 5));
      end
      if ($urandom_range(0, 1)) add_eot();
    end
    add_eot();

    wait (pending_text.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d text items, %0d results compared", item_count, result_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/latp_pkg.sv
hw/rtl/latp_front.sv
hw/rtl/latp_back.sv
hw/rtl/led_animation_text_parser_core.sv
hw/rtl/latp_checker.sv
bench/led_animation_text_parser_core_tb.sv
